[rtl/core/hrlc_pkg.sv]
// ----------------------------------------------------------------------------
// hrlc_pkg
// Types and constants shared by the hex record line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

    localparam int CHAR_W         = 8;
    localparam int VERDICT_W      = 3;
    localparam int NIBBLE_W       = 4;
    localparam int DIGIT_CNT_W    = 10;
    localparam int PHASE_W        = 2;

    // Fixed record overhead in hex digits: count, address, type, checksum.
    localparam int MIN_RECORD_DIGITS = 10;

    localparam logic [DIGIT_CNT_W-1:0] DIGIT_LIMIT = '1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;

    localparam logic [PHASE_W-1:0] PH_START  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BLANK  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RECORD = 2'd2;

    localparam logic [VERDICT_W-1:0] VD_VALID        = 3'd0;
    localparam logic [VERDICT_W-1:0] VD_BAD_FORMAT   = 3'd1;
    localparam logic [VERDICT_W-1:0] VD_ODD_DIGITS   = 3'd2;
    localparam logic [VERDICT_W-1:0] VD_BAD_LENGTH   = 3'd3;
    localparam logic [VERDICT_W-1:0] VD_BAD_CHECKSUM = 3'd4;

    typedef struct packed {
        logic                is_space;
        logic                is_colon;
        logic                is_hex;
        logic [NIBBLE_W-1:0] nibble;
    } char_class_t;

endpackage

[rtl/core/hrlc_if.sv]
// ----------------------------------------------------------------------------
// hrlc_if
// Valid/ready channels for character words and verdict words.
// ----------------------------------------------------------------------------
interface hrlc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface hrlc_verdict_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/core/hrlc_char_class.sv]
// ----------------------------------------------------------------------------
// hrlc_char_class
// Classifies one character: whitespace, colon, hex digit and its value.
// ----------------------------------------------------------------------------
module hrlc_char_class (
    input  logic [hrlc_pkg::CHAR_W-1:0] char_code,
    output hrlc_pkg::char_class_t       cls
);
    import hrlc_pkg::*;

    logic [CHAR_W-1:0] diff;

    always_comb
    begin
        cls.is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                       (char_code == CH_CR)    || (char_code == CH_LF);
        cls.is_colon = (char_code == CH_COLON);
        cls.is_hex   = 1'b1;
        diff         = '0;
        priority if (char_code >= CH_0 && char_code <= CH_9)
        begin
            diff = char_code - CH_0;
        end
        else if (char_code >= CH_UA && char_code <= CH_UF)
        begin
            diff = char_code - CH_UA + 8'd10;
        end
        else if (char_code >= CH_LA && char_code <= CH_LF_HEX)
        begin
            diff = char_code - CH_LA + 8'd10;
        end
        else
        begin
            cls.is_hex = 1'b0;
        end
        cls.nibble = diff[NIBBLE_W-1:0];
    end

endmodule

[rtl/core/hrlc_line_state.sv]
// ----------------------------------------------------------------------------
// hrlc_line_state
// Per-line state: phase, format flag, digit pairing, count byte, byte sum.
// Produces the line verdict on the last character.
// ----------------------------------------------------------------------------
module hrlc_line_state (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           last,
    input  hrlc_pkg::char_class_t          cls,
    output logic [hrlc_pkg::VERDICT_W-1:0] verdict,
    output logic [hrlc_pkg::PHASE_W-1:0]   phase
);
    import hrlc_pkg::*;

    logic [PHASE_W-1:0]     phase_reg,     phase_next;
    logic                   fmt_err_reg,   fmt_err_next;
    logic [NIBBLE_W-1:0]    high_nib_reg,  high_nib_next;
    logic [DIGIT_CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [7:0]             count_reg,     count_next;
    logic [7:0]             sum_reg,       sum_next;
    logic [7:0]             byte_val;
    logic [DIGIT_CNT_W:0]   expect_len;

    assign byte_val   = {high_nib_reg, cls.nibble};
    assign expect_len = {2'b00, count_next, 1'b0} + (DIGIT_CNT_W+1)'(MIN_RECORD_DIGITS);
    assign phase      = phase_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        fmt_err_next   = fmt_err_reg;
        high_nib_next  = high_nib_reg;
        digit_cnt_next = digit_cnt_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        unique case (phase_reg)
            PH_START:
            begin
                if (cls.is_space)
                begin
                    phase_next = PH_BLANK;
                end
                else
                begin
                    phase_next = PH_RECORD;
                    if (!cls.is_colon)
                    begin
                        fmt_err_next = 1'b1;
                    end
                end
            end
            PH_BLANK:
            begin
                if (!cls.is_space)
                begin
                    phase_next   = PH_RECORD;
                    fmt_err_next = 1'b1;
                end
            end
            default:
            begin
                if (!cls.is_hex)
                begin
                    fmt_err_next = 1'b1;
                end
                else
                begin
                    if (!digit_cnt_reg[0])
                    begin
                        high_nib_next = cls.nibble;
                    end
                    else
                    begin
                        if (digit_cnt_reg == DIGIT_CNT_W'(1))
                        begin
                            count_next = byte_val;
                        end
                        sum_next = sum_reg + byte_val;
                    end
                    // saturate while keeping parity exact
                    if (digit_cnt_reg == DIGIT_LIMIT)
                    begin
                        digit_cnt_next = DIGIT_LIMIT - DIGIT_CNT_W'(1);
                    end
                    else
                    begin
                        digit_cnt_next = digit_cnt_reg + DIGIT_CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        priority if (phase_next == PH_BLANK)
        begin
            verdict = VD_VALID;
        end
        else if (fmt_err_next || digit_cnt_next == '0)
        begin
            verdict = VD_BAD_FORMAT;
        end
        else if (digit_cnt_next[0])
        begin
            verdict = VD_ODD_DIGITS;
        end
        else if (expect_len != {1'b0, digit_cnt_next})
        begin
            verdict = VD_BAD_LENGTH;
        end
        else if (sum_next != 8'h00)
        begin
            verdict = VD_BAD_CHECKSUM;
        end
        else
        begin
            verdict = VD_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            fmt_err_reg   <= 1'b0;
            high_nib_reg  <= '0;
            digit_cnt_reg <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg     <= PH_START;
                fmt_err_reg   <= 1'b0;
                high_nib_reg  <= '0;
                digit_cnt_reg <= '0;
                count_reg     <= '0;
                sum_reg       <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                fmt_err_reg   <= fmt_err_next;
                high_nib_reg  <= high_nib_next;
                digit_cnt_reg <= digit_cnt_next;
                count_reg     <= count_next;
                sum_reg       <= sum_next;
            end
        end
    end

endmodule

[rtl/core/hex_record_line_checker.sv]
// ----------------------------------------------------------------------------
// hex_record_line_checker
// Streaming checker for hex-record text lines, one character word per item.
// ----------------------------------------------------------------------------
// Takes one character word per clock and gives one verdict word for each line.
// The verdict is offered from the clock edge at which the line's last character
// leaves the input register. A character is held in the input register and is
// then folded into the line state; the verdict of a line end goes to an output
// register, so characters keep flowing while a verdict waits. Throughput is one
// character per clock; only a line end that meets a full, stalled output
// register holds the input.
module hex_record_line_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    hrlc_char_if.sink            char_stream,
    hrlc_verdict_if.source       verdict_stream
);
    import hrlc_pkg::*;

    logic                 in_vld_reg;
    logic [CHAR_W-1:0]    in_char_reg;
    logic                 in_end_reg;
    logic                 out_vld_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic                 out_free;
    logic                 advance;
    char_class_t          cls;
    logic [VERDICT_W-1:0] line_verdict;
    logic [PHASE_W-1:0]   phase;

    assign out_free          = !out_vld_reg || verdict_stream.ready;
    assign advance           = in_vld_reg && (!in_end_reg || out_free);
    assign char_stream.ready = !in_vld_reg || advance;

    hrlc_char_class u_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    hrlc_line_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .last    (in_end_reg),
        .cls     (cls),
        .verdict (line_verdict),
        .phase   (phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (char_stream.ready)
            begin
                in_vld_reg <= char_stream.valid;
            end
            if (advance && in_end_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (verdict_stream.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.valid && char_stream.ready)
        begin
            in_char_reg <= char_stream.char_code;
            in_end_reg  <= char_stream.line_end;
        end
        if (advance && in_end_reg)
        begin
            out_verdict_reg <= line_verdict;
        end
    end

    assign verdict_stream.valid   = out_vld_reg;
    assign verdict_stream.verdict = out_verdict_reg;

`ifndef ASSERT_OFF
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_verdict_reg == VD_VALID ||
                         out_verdict_reg == VD_BAD_FORMAT ||
                         out_verdict_reg == VD_ODD_DIGITS ||
                         out_verdict_reg == VD_BAD_LENGTH ||
                         out_verdict_reg == VD_BAD_CHECKSUM))
        else $error("verdict code out of range");

    a_line_end_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> out_vld_reg)
        else $error("line end did not post a verdict");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !verdict_stream.ready) |-> !(advance && in_end_reg))
        else $error("pending verdict overwritten");

    a_phase_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> (phase == PH_START))
        else $error("line state not cleared after line end");
`endif

endmodule
